/* src/mck_pkg.sv */
// Package for the Morse character keyer: segment kinds, character classes,
// controller states, command/status structs and the Morse code tables.
// No dependencies.
package mck_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned DUR_W    = 18;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned PAT_W    = 5;   // longest code has five elements
    localparam int unsigned LEN_W    = 3;
    localparam int unsigned IDX_W    = 3;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd60;

    localparam logic [KIND_W-1:0] KIND_DOT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DASH    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GAP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

    typedef enum logic [1:0] {
        CLS_CODE,
        CLS_SPACE,
        CLS_UNKNOWN
    } t_cls;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    // Element patterns, first element in the top bit, 1 = dash.
    localparam logic [PAT_W-1:0] LETTER_PAT [26] = '{
        5'b01000, 5'b10000, 5'b10100, 5'b10000, 5'b00000, 5'b00100,
        5'b11000, 5'b00000, 5'b00000, 5'b01110, 5'b10100, 5'b01000,
        5'b11000, 5'b10000, 5'b11100, 5'b01100, 5'b11010, 5'b01000,
        5'b00000, 5'b10000, 5'b00100, 5'b00010, 5'b01100, 5'b10010,
        5'b10110, 5'b11000
    };

    localparam logic [LEN_W-1:0] LETTER_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
        3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
        3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };

    localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
        5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
        5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
    };

    localparam logic [LEN_W-1:0] DIGIT_LEN = 3'd5;

    typedef struct packed {
        t_cls             cls;
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] len;
    } t_code;

    typedef struct packed {
        logic load;     // take a new character
        logic advance;  // step to the next segment
    } t_cmd;

    typedef struct packed {
        logic last;     // current segment closes the character
    } t_sts;

    function automatic t_code code_lookup(input logic [CHAR_W-1:0] ch);
        t_code             res;
        logic [CHAR_W-1:0] off;
        res.cls     = CLS_UNKNOWN;
        res.pattern = '0;
        res.len     = '0;
        off         = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            off         = ch - CHAR_UPPER_A;
            res.cls     = CLS_CODE;
            res.pattern = LETTER_PAT[off[4:0]];
            res.len     = LETTER_LEN[off[4:0]];
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            off         = ch - CHAR_LOWER_A;
            res.cls     = CLS_CODE;
            res.pattern = LETTER_PAT[off[4:0]];
            res.len     = LETTER_LEN[off[4:0]];
        end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            off         = ch - CHAR_ZERO;
            res.cls     = CLS_CODE;
            res.pattern = DIGIT_PAT[off[3:0]];
            res.len     = DIGIT_LEN;
        end else if (ch == CHAR_SPACE) begin
            res.cls     = CLS_SPACE;
        end
        return res;
    endfunction

endpackage

/* src/mck_if.sv */
// Channel interfaces of the Morse character keyer: character in, segment out,
// unit time write. Depends on mck_pkg for field widths.
interface mck_chr_if ();
    logic                        valid;
    logic                        ready;
    logic [mck_pkg::CHAR_W-1:0]  character;
    modport source (output valid, character, input ready);
    modport sink   (input valid, character, output ready);
endinterface

interface mck_seg_if ();
    logic                        valid;
    logic                        ready;
    logic                        key_on;
    logic [mck_pkg::DUR_W-1:0]   duration;
    logic [mck_pkg::KIND_W-1:0]  element_kind;
    logic                        unknown_char;
    logic                        last_segment;
    modport source (output valid, key_on, duration, element_kind, unknown_char,
                    last_segment, input ready);
    modport sink   (input valid, key_on, duration, element_kind, unknown_char,
                    last_segment, output ready);
endinterface

interface mck_cfg_if ();
    logic                        valid;
    logic                        ready;
    logic [mck_pkg::UNIT_W-1:0]  unit_time;
    modport source (output valid, unit_time, input ready);
    modport sink   (input valid, unit_time, output ready);
endinterface

/* src/mck_ctrl.sv */
// Controller of the Morse character keyer: handshakes and segment sequencing.
// Depends on mck_pkg (states, command and status structs).
module mck_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mck_pkg::t_cmd o_cmd,
    input  mck_pkg::t_sts i_sts
);

    mck_pkg::t_state r_state;
    mck_pkg::t_state n_state;
    logic            in_acc;
    logic            out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mck_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mck_pkg::ST_IDLE: begin
                if (in_acc) n_state = mck_pkg::ST_SEND;
            end
            mck_pkg::ST_SEND: begin
                if (out_acc && i_sts.last && !in_acc) n_state = mck_pkg::ST_IDLE;
            end
            default: n_state = mck_pkg::ST_IDLE;
        endcase
    end

    // Take the next character in the cycle the final segment leaves.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            mck_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            mck_pkg::ST_SEND: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_sts.last && i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load    = in_acc;
        o_cmd.advance = out_acc && !i_sts.last;
    end

endmodule

/* src/mck_dpath.sv */
// Datapath of the Morse character keyer: unit time register, code lookup,
// element counter and segment field formation. Depends on mck_pkg.
module mck_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [mck_pkg::UNIT_W-1:0]  i_cfg_unit,
    input  logic [mck_pkg::CHAR_W-1:0]  i_char,
    input  mck_pkg::t_cmd               i_cmd,
    output mck_pkg::t_sts               o_sts,
    output logic                        o_key_on,
    output logic [mck_pkg::DUR_W-1:0]   o_duration,
    output logic [mck_pkg::KIND_W-1:0]  o_element_kind,
    output logic                        o_unknown_char,
    output logic                        o_last_segment
);

    logic [mck_pkg::UNIT_W-1:0] r_unit;
    mck_pkg::t_cls              r_cls;
    logic [mck_pkg::PAT_W-1:0]  r_pattern;
    logic [mck_pkg::LEN_W-1:0]  r_len;
    logic [mck_pkg::IDX_W-1:0]  r_idx;
    logic                       r_off;     // key-off half of the element
    mck_pkg::t_code             code;
    logic                       dash;
    logic [mck_pkg::IDX_W-1:0]  bit_sel;
    logic [mck_pkg::DUR_W-1:0]  dur_one;
    logic [mck_pkg::DUR_W-1:0]  dur_four;
    logic                       last;

    assign code = mck_pkg::code_lookup(i_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= mck_pkg::UNIT_RESET;
        end else if (i_cfg_valid) begin
            r_unit <= i_cfg_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cls     <= code.cls;
            r_pattern <= code.pattern;
            r_len     <= code.len;
            r_idx     <= '0;
            r_off     <= 1'b0;
        end else if (i_cmd.advance) begin
            r_off <= !r_off;
            if (r_off) r_idx <= r_idx + 1'b1;
        end
    end

    assign bit_sel  = mck_pkg::IDX_W'(mck_pkg::PAT_W - 1) - r_idx;
    assign dash     = r_pattern[bit_sel];
    assign dur_one  = {2'b00, r_unit};
    assign dur_four = {r_unit, 2'b00};

    always_comb begin
        o_key_on       = 1'b0;
        o_duration     = '0;
        o_element_kind = mck_pkg::KIND_UNKNOWN;
        o_unknown_char = 1'b0;
        last           = 1'b1;
        case (r_cls)
            mck_pkg::CLS_CODE: begin
                o_key_on       = !r_off;
                o_duration     = (dash && !r_off) ? dur_four : dur_one;
                o_element_kind = dash ? mck_pkg::KIND_DASH : mck_pkg::KIND_DOT;
                last           = r_off && (r_idx == r_len - 1'b1);
            end
            mck_pkg::CLS_SPACE: begin
                o_duration     = dur_four;
                o_element_kind = mck_pkg::KIND_GAP;
            end
            default: begin
                o_unknown_char = 1'b1;
            end
        endcase
    end

    assign o_last_segment = last;
    assign o_sts.last     = last;

endmodule

/* src/morse_character_keyer.sv */
// Morse character keyer: one ASCII character in, its keying out as timed
// segments, one segment per cycle while the output is taken. A letter or digit
// of n elements gives 2n segments; a space or an unknown character gives one.
// The segment sequencer steps one key-on or key-off segment a cycle, and the
// next character is taken in the same cycle as the last segment of the current
// one. The unit time register may be written only while no character is in
// progress.
module morse_character_keyer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mck_chr_if.sink    i_chr,
    mck_seg_if.source  o_seg,
    mck_cfg_if.sink    i_cfg
);

    mck_pkg::t_cmd cmd;
    mck_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    mck_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_chr.valid),
        .o_in_ready  (i_chr.ready),
        .o_out_valid (o_seg.valid),
        .i_out_ready (o_seg.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mck_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_unit     (i_cfg.unit_time),
        .i_char         (i_chr.character),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_key_on       (o_seg.key_on),
        .o_duration     (o_seg.duration),
        .o_element_kind (o_seg.element_kind),
        .o_unknown_char (o_seg.unknown_char),
        .o_last_segment (o_seg.last_segment)
    );

`ifndef SYNTHESIS
    a_accept_starts_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_chr.valid && i_chr.ready) |=> o_seg.valid)
        else $error("no segment after a character was taken");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && o_seg.ready && o_seg.last_segment &&
         !(i_chr.valid && i_chr.ready)) |=> !o_seg.valid)
        else $error("segment shown after the final one left");

    a_unknown_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && o_seg.unknown_char) |->
        (o_seg.last_segment && o_seg.duration == '0 && !o_seg.key_on))
        else $error("unknown character segment malformed");

    a_key_on_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_seg.valid && o_seg.key_on) |-> !o_seg.last_segment)
        else $error("key-on segment marked final");
`endif

endmodule

/* test/morse_character_keyer_tb.sv */
`timescale 1ns / 100ps
// Testbench for morse_character_keyer: streams characters in and checks every
// keying segment against a local Morse predictor.
// Depends on mck_pkg, the channel interfaces in mck_if and the keyer RTL.
module morse_character_keyer_tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 30;
    localparam int PRINT_CAP       = 50;

    typedef struct packed {
        logic                       key_on;
        logic [mck_pkg::DUR_W-1:0]  duration;
        logic [mck_pkg::KIND_W-1:0] kind;
        logic                       unknown;
        logic                       last;
    } t_segment;

    logic clk;
    logic rst_n;

    mck_chr_if chr ();
    mck_seg_if seg ();
    mck_cfg_if cfg ();

    morse_character_keyer u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_chr   (chr.sink),
        .o_seg   (seg.source),
        .i_cfg   (cfg.sink)
    );

    string letter_morse [26] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--.."
    };
    string digit_morse [10] = '{
        "-----", ".----", "..---", "...--", "....-",
        ".....", "-....", "--...", "---..", "----."
    };

    // Range ends, both cases of F, and the codes just outside each range.
    logic [mck_pkg::CHAR_W-1:0] directed_chars [23] = '{
        "A", "Z", "a", "z", "F", "f", "E", "T", "0", "5", "9", " ",
        8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A,
        8'h1F, 8'h21, 8'h80
    };

    logic [mck_pkg::UNIT_W-1:0] unit_now = mck_pkg::UNIT_RESET;
    logic [mck_pkg::CHAR_W-1:0] chars_pending [$];
    t_segment                   segs_due [$];
    int                         faults = 0;
    int                         cycles = 0;

    int   burst_left = 0;
    int   gap_left = 0;
    logic hold_off_req = 1'b0;
    bit   hold_off_taken = 1'b0;
    int   hold_left = 0;
    logic [7:0] stall_pat = 8'hFF;
    int   pat_left = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_fault(input string msg);
        if (faults < PRINT_CAP)
            $display("%0t ns: %s", $time, msg);
        faults++;
    endtask

    // Push the segments one character should produce at the current unit time.
    function automatic void predict_segments(input logic [mck_pkg::CHAR_W-1:0] c);
        string                     code;
        t_segment                  s;
        logic [mck_pkg::DUR_W-1:0] one_unit;
        logic                      is_dash;
        int                        i;
        one_unit  = {2'b00, unit_now};
        code      = "";
        s.key_on  = 1'b0;
        s.unknown = 1'b0;
        s.last    = 1'b1;
        if (c >= mck_pkg::CHAR_UPPER_A && c <= mck_pkg::CHAR_UPPER_Z)
            code = letter_morse[c - mck_pkg::CHAR_UPPER_A];
        else if (c >= mck_pkg::CHAR_LOWER_A && c <= mck_pkg::CHAR_LOWER_Z)
            code = letter_morse[c - mck_pkg::CHAR_LOWER_A];
        else if (c >= mck_pkg::CHAR_ZERO && c <= mck_pkg::CHAR_NINE)
            code = digit_morse[c - mck_pkg::CHAR_ZERO];
        if (c == mck_pkg::CHAR_SPACE) begin
            s.duration = one_unit << 2;
            s.kind     = mck_pkg::KIND_GAP;
            segs_due.push_back(s);
        end else if (code.len() == 0) begin
            s.duration = '0;
            s.kind     = mck_pkg::KIND_UNKNOWN;
            s.unknown  = 1'b1;
            segs_due.push_back(s);
        end else begin
            for (i = 0; i < code.len(); i++) begin
                is_dash    = (code[i] == "-");
                s.kind     = is_dash ? mck_pkg::KIND_DASH : mck_pkg::KIND_DOT;
                s.key_on   = 1'b1;
                s.duration = is_dash ? (one_unit << 2) : one_unit;
                s.last     = 1'b0;
                segs_due.push_back(s);
                // key-off space after the element keeps its kind
                s.key_on   = 1'b0;
                s.duration = one_unit;
                s.last     = (i == code.len() - 1);
                segs_due.push_back(s);
            end
        end
    endfunction

    // Mostly text, with the odd arbitrary byte.
    function automatic logic [mck_pkg::CHAR_W-1:0] random_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)
            return mck_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
        if (pick < 11)
            return mck_pkg::CHAR_LOWER_A + 8'($urandom_range(0, 25));
        if (pick < 14)
            return mck_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
        if (pick < 16)
            return mck_pkg::CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Character driver: bursts of random length, random gaps between them.
    always @(posedge clk) begin
        logic                       offer;
        logic [mck_pkg::CHAR_W-1:0] next_char;
        if (!rst_n) begin
            chr.valid     <= 1'b0;
            chr.character <= '0;
        end else begin
            if (chr.valid && chr.ready) begin
                predict_segments(chr.character);
                void'(chars_pending.pop_front());
            end
            // hold the item while it is offered and not yet taken
            if (!(chr.valid && !chr.ready)) begin
                offer     = 1'b0;
                next_char = chr.character;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (chars_pending.size() != 0) begin
                    offer     = 1'b1;
                    next_char = chars_pending[0];
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                chr.valid     <= offer;
                chr.character <= next_char;
            end
        end
    end

    // Segment monitor and receiver stall pattern.
    always @(posedge clk) begin
        t_segment want;
        logic     take;
        if (!rst_n) begin
            seg.ready <= 1'b0;
        end else begin
            if (seg.valid && seg.ready) begin
                if (segs_due.size() == 0) begin
                    report_fault($sformatf("segment with nothing due: on %0b dur %0d kind %0d",
                                           seg.key_on, seg.duration, seg.element_kind));
                end else begin
                    want = segs_due.pop_front();
                    if (seg.key_on !== want.key_on)
                        report_fault($sformatf("key_on got %0b want %0b",
                                               seg.key_on, want.key_on));
                    if (seg.duration !== want.duration)
                        report_fault($sformatf("duration got %0d want %0d",
                                               seg.duration, want.duration));
                    if (seg.element_kind !== want.kind)
                        report_fault($sformatf("element_kind got %0d want %0d",
                                               seg.element_kind, want.kind));
                    if (seg.unknown_char !== want.unknown)
                        report_fault($sformatf("unknown_char got %0b want %0b",
                                               seg.unknown_char, want.unknown));
                    if (seg.last_segment !== want.last)
                        report_fault($sformatf("last_segment got %0b want %0b",
                                               seg.last_segment, want.last));
                end
            end
            if (hold_off_req && !hold_off_taken) begin
                hold_left      = HOLD_OFF_CYCLES;
                hold_off_taken = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                take = 1'b0;
            end else begin
                if (pat_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_pat = 8'hFF;
                        1:       stall_pat = 8'h11;
                        default: stall_pat = 8'($urandom_range(1, 255));
                    endcase
                    pat_left = $urandom_range(8, 64);
                end
                pat_left--;
                take      = stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[7:1]};
            end
            seg.ready <= take;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_unit_time(input logic [mck_pkg::UNIT_W-1:0] value);
        cfg.valid     <= 1'b1;
        cfg.unit_time <= value;
        do @(posedge clk); while (!cfg.ready);
        unit_now = value;
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (chars_pending.size() != 0 || segs_due.size() != 0);
    endtask

    initial begin
        rst_n         = 1'b0;
        chr.valid     = 1'b0;
        chr.character = '0;
        seg.ready     = 1'b0;
        cfg.valid     = 1'b0;
        cfg.unit_time = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed characters at the reset unit time
        foreach (directed_chars[i])
            chars_pending.push_back(directed_chars[i]);
        wait_idle();

        write_unit_time(16'd1);
        repeat (25) chars_pending.push_back(random_char());
        wait_idle();

        // longest durations; hold the output off so the input backs up
        write_unit_time(16'hFFFF);
        chars_pending.push_back("0");
        chars_pending.push_back(" ");
        repeat (28) chars_pending.push_back(random_char());
        hold_off_req <= 1'b1;
        wait_idle();

        write_unit_time('0);
        chars_pending.push_back(" ");
        chars_pending.push_back("Q");
        repeat (15) chars_pending.push_back(random_char());
        wait_idle();

        write_unit_time(16'($urandom_range(2, 65534)));
        repeat (30) chars_pending.push_back(random_char());
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
